@@ rtl/core/dtrm_pkg.sv @@
`timescale 1ns / 1ps

package dtrm_pkg;

   localparam int PIX_BITS          = 11;
   localparam int CSR_INDEX_BITS    = 2;
   localparam int DEF_TILE_PIXELS   = 16;
   localparam int DEF_MAX_TILE_COLS = 64;
   localparam int DEF_MAX_TILE_ROWS = 64;

   localparam logic [PIX_BITS-1:0] SCREEN_WIDTH_RESET  = 11'd320;
   localparam logic [PIX_BITS-1:0] SCREEN_HEIGHT_RESET = 11'd240;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_SCREEN_WIDTH  = 2'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_SCREEN_HEIGHT = 2'd1;

   typedef enum logic [1:0] {
      KIND_MARK  = 2'd0,
      KIND_SWAP  = 2'd1,
      KIND_CLEAR = 2'd2,
      KIND_QUERY = 2'd3
   } kind_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CLIP,
      ST_DIV_MUL,
      ST_DIV_STORE,
      ST_RANGE,
      ST_MARK,
      ST_QUERY
   } state_type;

   typedef struct packed {
      kind_type           kind;
      logic signed [15:0] rect_x;
      logic signed [15:0] rect_y;
      logic signed [15:0] rect_w;
      logic signed [15:0] rect_h;
      logic [5:0]         tile_col;
      logic [5:0]         tile_row;
   } req_type;

   typedef struct packed {
      logic current_dirty;
      logic previous_dirty;
      logic region_ignored;
   } rsp_type;

   typedef struct packed {
      logic rd_en;
      logic wr_en;
      logic swap;
      logic clear_all;
   } map_cmd_type;

endpackage

@@ rtl/core/dtrm_recip_unit.sv @@
`timescale 1ns / 1ps

module dtrm_recip_unit import dtrm_pkg::*; #(
   parameter int TILE_PIXELS = DEF_TILE_PIXELS
) (
   input  logic                clock,
   input  logic                enable,
   input  logic [PIX_BITS-1:0] operand,
   output logic [PIX_BITS-1:0] quotient
);

   // The rounded-up reciprocal is exact for every operand below 2**PIX_BITS
   // because the rounding error times the operand stays below 2**SHIFT.
   localparam int SHIFT   = PIX_BITS + 7;
   localparam int RECIP_W = SHIFT + 1;
   localparam int PROD_W  = PIX_BITS + RECIP_W;
   localparam logic [RECIP_W-1:0] RECIP =
      RECIP_W'(((1 << SHIFT) + TILE_PIXELS - 1) / TILE_PIXELS);

   logic [PROD_W-1:0] prod_ff;
   logic [PROD_W-1:0] prod_in;

   assign prod_in  = PROD_W'(operand) * PROD_W'(RECIP);
   assign quotient = prod_ff[SHIFT +: PIX_BITS];

   always_ff @(posedge clock) begin
      if (enable) begin
         prod_ff <= prod_in;
      end
   end

endmodule

@@ rtl/core/dtrm_map_store.sv @@
`timescale 1ns / 1ps

module dtrm_map_store import dtrm_pkg::*; #(
   parameter int MAX_TILE_COLS = DEF_MAX_TILE_COLS,
   parameter int MAX_TILE_ROWS = DEF_MAX_TILE_ROWS,
   parameter int ROW_W         = (MAX_TILE_ROWS > 1) ? $clog2(MAX_TILE_ROWS) : 1
) (
   input  logic                     clock,
   input  logic                     reset,
   input  map_cmd_type              cmd,
   input  logic [ROW_W-1:0]         rd_row,
   input  logic [ROW_W-1:0]         wr_row,
   input  logic [MAX_TILE_COLS-1:0] wr_data,
   output logic [MAX_TILE_COLS-1:0] cur_word,
   output logic [MAX_TILE_COLS-1:0] prev_word
);

   logic [MAX_TILE_COLS-1:0] mem_a [MAX_TILE_ROWS];
   logic [MAX_TILE_COLS-1:0] mem_b [MAX_TILE_ROWS];

   logic [MAX_TILE_ROWS-1:0] valid_a_ff, valid_a_in;
   logic [MAX_TILE_ROWS-1:0] valid_b_ff, valid_b_in;
   logic                     bank_ff, bank_in;
   logic [MAX_TILE_COLS-1:0] a_q_ff, b_q_ff;
   logic                     va_q_ff, vb_q_ff;
   logic [MAX_TILE_COLS-1:0] word_a, word_b;

   always_ff @(posedge clock) begin
      if (cmd.wr_en && !bank_ff) begin
         mem_a[wr_row] <= wr_data;
      end
      if (cmd.wr_en && bank_ff) begin
         mem_b[wr_row] <= wr_data;
      end
      if (cmd.rd_en) begin
         a_q_ff  <= mem_a[rd_row];
         b_q_ff  <= mem_b[rd_row];
         va_q_ff <= valid_a_ff[rd_row];
         vb_q_ff <= valid_b_ff[rd_row];
      end
   end

   // Rows that were never written since the last clear read as empty.
   always_comb begin
      valid_a_in = valid_a_ff;
      valid_b_in = valid_b_ff;
      bank_in    = bank_ff;
      if (cmd.wr_en) begin
         if (bank_ff) begin
            valid_b_in[wr_row] = 1'b1;
         end else begin
            valid_a_in[wr_row] = 1'b1;
         end
      end
      if (cmd.swap) begin
         bank_in = ~bank_ff;
         if (bank_ff) begin
            valid_a_in = '0;
         end else begin
            valid_b_in = '0;
         end
      end
      if (cmd.clear_all) begin
         valid_a_in = '0;
         valid_b_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_a_ff <= '0;
         valid_b_ff <= '0;
         bank_ff    <= 1'b0;
      end else begin
         valid_a_ff <= valid_a_in;
         valid_b_ff <= valid_b_in;
         bank_ff    <= bank_in;
      end
   end

   assign word_a    = va_q_ff ? a_q_ff : '0;
   assign word_b    = vb_q_ff ? b_q_ff : '0;
   assign cur_word  = bank_ff ? word_b : word_a;
   assign prev_word = bank_ff ? word_a : word_b;

endmodule

@@ rtl/core/dirty_tile_region_marker.sv @@
`timescale 1ns / 1ps

// Dirty tile tracker with a current and a previous tile map.
// A command transfer is taken when start is high and busy is low. Each
// command gives exactly one result, shown for a single cycle with
// rsp_strobe high; the receiver cannot stall, so it must take it then.
// Swap and clear commands finish in the cycle they are taken and their
// result follows in the next cycle; busy stays low.
// A query reads the row of both maps when it is taken, picks its tile bit in
// ST_QUERY, and the result is registered from there.
// A mark clips the rectangle in ST_CLIP, converts each of its edges to tile
// coordinates through one shared reciprocal multiplier, in ST_DIV_MUL and
// ST_DIV_STORE for each edge, builds the column mask in ST_RANGE, and then
// updates one map row per cycle in a read-modify-write pipeline of the row
// memory. A mark that covers no screen pixel ends after the clip cycle; one
// whose tiles all lie outside the map ends in ST_RANGE.
// Reset empties both maps at once and restores the screen size registers to
// 320 by 240. The user writes the screen size through the csr_ port only
// while idle, which the block does not enforce; this never changes the maps.

module dirty_tile_region_marker import dtrm_pkg::*; #(
   parameter int TILE_PIXELS   = DEF_TILE_PIXELS,
   parameter int MAX_TILE_COLS = DEF_MAX_TILE_COLS,
   parameter int MAX_TILE_ROWS = DEF_MAX_TILE_ROWS
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   input  req_type                   req_data,
   output logic                      busy,
   output logic                      rsp_strobe,
   output rsp_type                   rsp_data,
   input  logic                      csr_we,
   input  logic [CSR_INDEX_BITS-1:0] csr_index,
   input  logic [PIX_BITS-1:0]       csr_wdata
);

   localparam int ROW_W  = (MAX_TILE_ROWS > 1) ? $clog2(MAX_TILE_ROWS) : 1;
   localparam int COL_W  = (MAX_TILE_COLS > 1) ? $clog2(MAX_TILE_COLS) : 1;
   localparam int WIDE   = 18;
   localparam logic [PIX_BITS-1:0] COL_LAST = PIX_BITS'(MAX_TILE_COLS - 1);
   localparam logic [PIX_BITS-1:0] ROW_LAST = PIX_BITS'(MAX_TILE_ROWS - 1);

   state_type state_ff, state_in;
   req_type   item_ff, item_in;
   logic [PIX_BITS-1:0] screen_w_ff, screen_h_ff;
   logic [PIX_BITS-1:0] pix_ff [4];
   logic [PIX_BITS-1:0] pix_in [4];
   logic [PIX_BITS-1:0] tile_ff [4];
   logic [PIX_BITS-1:0] tile_in [4];
   logic [1:0]          idx_ff, idx_in;
   logic [MAX_TILE_COLS-1:0] mask_ff, mask_in;
   logic [ROW_W-1:0]    row_ff, row_in;
   logic [ROW_W-1:0]    last_row_ff, last_row_in;
   logic [ROW_W-1:0]    wrow_ff, wrow_in;
   logic                issue_ff, issue_in;
   logic                rsp_strobe_ff, rsp_strobe_in;
   rsp_type             rsp_ff, rsp_in;

   map_cmd_type              map_cmd;
   logic [ROW_W-1:0]         rd_row;
   logic [MAX_TILE_COLS-1:0] wr_data;
   logic [MAX_TILE_COLS-1:0] cur_word, prev_word;
   logic [PIX_BITS-1:0]      quotient;
   logic                     div_en;

   logic signed [WIDE-1:0] xs, ys, ws, hs;
   logic signed [WIDE-1:0] x_end, y_end, x_lim, y_lim;
   logic signed [WIDE-1:0] x1c, y1c, x2c, y2c;
   logic                   clip_empty;
   logic [PIX_BITS-1:0]    tx2c, ty2c;
   logic [8:0]             req_row_ext, item_row_ext;
   logic                   query_hit;
   logic [COL_W-1:0]       query_col;

   dtrm_map_store #(
      .MAX_TILE_COLS (MAX_TILE_COLS),
      .MAX_TILE_ROWS (MAX_TILE_ROWS),
      .ROW_W         (ROW_W)
   ) u_map_store (
      .clock     (clock),
      .reset     (reset),
      .cmd       (map_cmd),
      .rd_row    (rd_row),
      .wr_row    (wrow_ff),
      .wr_data   (wr_data),
      .cur_word  (cur_word),
      .prev_word (prev_word)
   );

   dtrm_recip_unit #(
      .TILE_PIXELS (TILE_PIXELS)
   ) u_recip_unit (
      .clock    (clock),
      .enable   (div_en),
      .operand  (pix_ff[idx_ff]),
      .quotient (quotient)
   );

   // Clipping is done wide enough that the far edge cannot overflow.
   always_comb begin
      xs    = WIDE'(item_ff.rect_x);
      ys    = WIDE'(item_ff.rect_y);
      ws    = WIDE'(item_ff.rect_w);
      hs    = WIDE'(item_ff.rect_h);
      x_end = xs + ws - WIDE'(1);
      y_end = ys + hs - WIDE'(1);
      x_lim = $signed(WIDE'(screen_w_ff)) - WIDE'(1);
      y_lim = $signed(WIDE'(screen_h_ff)) - WIDE'(1);
      x2c   = (x_end > x_lim) ? x_lim : x_end;
      y2c   = (y_end > y_lim) ? y_lim : y_end;
      x1c   = (xs > WIDE'(0)) ? xs : WIDE'(0);
      y1c   = (ys > WIDE'(0)) ? ys : WIDE'(0);
      clip_empty = (ws <= WIDE'(0)) || (hs <= WIDE'(0)) || (x1c > x2c) || (y1c > y2c);
   end

   assign tx2c         = (tile_ff[2] > COL_LAST) ? COL_LAST : tile_ff[2];
   assign ty2c         = (tile_ff[3] > ROW_LAST) ? ROW_LAST : tile_ff[3];
   assign req_row_ext  = 9'(req_data.tile_row);
   assign item_row_ext = 9'(item_ff.tile_row);
   assign query_col    = COL_W'(item_ff.tile_col);
   assign query_hit    = (7'(item_ff.tile_col) < 7'(MAX_TILE_COLS)) &&
                         (item_row_ext < 9'(MAX_TILE_ROWS));
   assign wr_data      = cur_word | mask_ff;

   always_comb begin
      state_in      = state_ff;
      item_in       = item_ff;
      pix_in        = pix_ff;
      tile_in       = tile_ff;
      idx_in        = idx_ff;
      mask_in       = mask_ff;
      row_in        = row_ff;
      last_row_in   = last_row_ff;
      wrow_in       = wrow_ff;
      issue_in      = issue_ff;
      rsp_strobe_in = 1'b0;
      rsp_in        = rsp_ff;
      map_cmd       = '0;
      rd_row        = req_row_ext[ROW_W-1:0];
      div_en        = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               item_in = req_data;
               rsp_in  = '0;
               case (req_data.kind)
                  KIND_MARK: begin
                     state_in = ST_CLIP;
                  end
                  KIND_SWAP: begin
                     map_cmd.swap  = 1'b1;
                     rsp_strobe_in = 1'b1;
                  end
                  KIND_CLEAR: begin
                     map_cmd.clear_all = 1'b1;
                     rsp_strobe_in     = 1'b1;
                  end
                  default: begin
                     map_cmd.rd_en = 1'b1;
                     state_in      = ST_QUERY;
                  end
               endcase
            end
         end
         ST_CLIP: begin
            if (clip_empty) begin
               rsp_in.region_ignored = 1'b1;
               rsp_strobe_in         = 1'b1;
               state_in              = ST_IDLE;
            end else begin
               pix_in[0] = x1c[PIX_BITS-1:0];
               pix_in[1] = y1c[PIX_BITS-1:0];
               pix_in[2] = x2c[PIX_BITS-1:0];
               pix_in[3] = y2c[PIX_BITS-1:0];
               idx_in    = 2'd0;
               state_in  = ST_DIV_MUL;
            end
         end
         ST_DIV_MUL: begin
            div_en   = 1'b1;
            state_in = ST_DIV_STORE;
         end
         ST_DIV_STORE: begin
            tile_in[idx_ff] = quotient;
            idx_in          = idx_ff + 2'd1;
            state_in        = (idx_ff == 2'd3) ? ST_RANGE : ST_DIV_MUL;
         end
         ST_RANGE: begin
            for (int c = 0; c < MAX_TILE_COLS; c++) begin
               mask_in[c] = (PIX_BITS'(c) >= tile_ff[0]) && (PIX_BITS'(c) <= tx2c);
            end
            row_in      = tile_ff[1][ROW_W-1:0];
            last_row_in = ty2c[ROW_W-1:0];
            issue_in    = 1'b1;
            if ((tile_ff[0] > tx2c) || (tile_ff[1] > ty2c)) begin
               rsp_strobe_in = 1'b1;
               state_in      = ST_IDLE;
            end else begin
               state_in = ST_MARK;
            end
         end
         ST_MARK: begin
            // Reads run one row ahead of the write-back of the row before.
            if (issue_ff) begin
               map_cmd.rd_en = 1'b1;
               rd_row        = row_ff;
               wrow_in       = row_ff;
               if (row_ff == last_row_ff) begin
                  issue_in = 1'b0;
               end else begin
                  row_in = row_ff + ROW_W'(1);
               end
            end
            if (row_ff != tile_ff[1][ROW_W-1:0] || !issue_ff) begin
               map_cmd.wr_en = 1'b1;
            end
            if (!issue_ff) begin
               rsp_strobe_in = 1'b1;
               state_in      = ST_IDLE;
            end
         end
         ST_QUERY: begin
            rsp_in.current_dirty  = query_hit && cur_word[query_col];
            rsp_in.previous_dirty = query_hit && prev_word[query_col];
            rsp_strobe_in         = 1'b1;
            state_in              = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         rsp_strobe_ff <= 1'b0;
         screen_w_ff   <= SCREEN_WIDTH_RESET;
         screen_h_ff   <= SCREEN_HEIGHT_RESET;
      end else begin
         state_ff      <= state_in;
         rsp_strobe_ff <= rsp_strobe_in;
         if (csr_we) begin
            case (csr_index)
               CSR_SCREEN_WIDTH:  screen_w_ff <= csr_wdata;
               CSR_SCREEN_HEIGHT: screen_h_ff <= csr_wdata;
               default: ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      item_ff     <= item_in;
      pix_ff      <= pix_in;
      tile_ff     <= tile_in;
      idx_ff      <= idx_in;
      mask_ff     <= mask_in;
      row_ff      <= row_in;
      last_row_ff <= last_row_in;
      wrow_ff     <= wrow_in;
      issue_ff    <= issue_in;
      rsp_ff      <= rsp_in;
   end

   assign busy       = (state_ff != ST_IDLE);
   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_data   = rsp_ff;

endmodule
